[rtl/nscc_pkg.sv]
// ----------------------------------------------------------------------------
// nscc_pkg
// Types, character constants and hex helpers shared by the NMEA sentence
// checksum checker.
// ----------------------------------------------------------------------------
package nscc_pkg;

  localparam logic [7:0] STAR_CHAR    = 8'h2A;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] SUM_INIT     = 8'h00;
  localparam logic [2:0] AFTER_SAT    = 3'd4;
  localparam logic [2:0] AFTER_NL_LEN = 3'd3;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_STAR  = 2'd1,
    STATUS_SHORT    = 2'd2,
    STATUS_MISMATCH = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       checksum_ok;
    status_e    status_code;
    logic [7:0] computed_sum;
  } out_item_t;

  // ascii hex digit of a nibble
  function automatic logic [7:0] hex_upper(input logic [3:0] nib);
    hex_upper = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
  endfunction

  function automatic logic [7:0] hex_lower(input logic [3:0] nib);
    hex_lower = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
  endfunction

endpackage

[rtl/nscc_in_stage.sv]
// ----------------------------------------------------------------------------
// nscc_in_stage
// Input register: captures one character transfer and holds it until the
// checking stage takes it.
// ----------------------------------------------------------------------------
module nscc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nscc_pkg::in_item_t in_data_i,
  input  logic               fire_i,
  output logic               valid_o,
  output nscc_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  nscc_pkg::in_item_t item_q;
  logic               accept;

  assign in_stall_o = valid_q & ~fire_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/nscc_core.sv]
// ----------------------------------------------------------------------------
// nscc_core
// Line state and checksum evaluation: folds one character into the running
// state and forms the line verdict on the last character.
// ----------------------------------------------------------------------------
module nscc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  nscc_pkg::in_item_t  item_i,
  output nscc_pkg::out_item_t res_o
);

  logic       skip_q, skip_d, skip_a;
  logic [7:0] xor_q, xor_d, xor_a;
  logic       star_q, star_d, star_a;
  logic [2:0] cnt_q, cnt_d, cnt_a;
  logic [7:0] dig1_q, dig1_d, dig1_a;
  logic [7:0] dig2_q, dig2_d, dig2_a;
  logic       nl_q, nl_d, nl_a;
  logic       long_enough;
  logic       match;

  // absorb the character
  always_comb begin
    skip_a = skip_q;
    xor_a  = xor_q;
    star_a = star_q;
    cnt_a  = cnt_q;
    dig1_a = dig1_q;
    dig2_a = dig2_q;
    nl_a   = nl_q;
    if (skip_q) begin
      skip_a = 1'b0;
    end else if (!star_q) begin
      if (item_i.char_byte == nscc_pkg::STAR_CHAR) begin
        star_a = 1'b1;
      end else begin
        xor_a = xor_q ^ item_i.char_byte;
      end
    end else begin
      unique case (cnt_q)
        3'd0:    dig1_a = item_i.char_byte;
        3'd1:    dig2_a = item_i.char_byte;
        3'd2:    nl_a   = (item_i.char_byte == nscc_pkg::NEWLINE_CHAR);
        default: ;
      endcase
      if (cnt_q < nscc_pkg::AFTER_SAT) begin
        cnt_a = cnt_q + 3'd1;
      end
    end
  end

  // verdict
  always_comb begin
    long_enough = (cnt_a >= nscc_pkg::AFTER_SAT) ||
                  ((cnt_a == nscc_pkg::AFTER_NL_LEN) && nl_a);
    match = ((dig1_a == nscc_pkg::hex_upper(xor_a[7:4])) &&
             (dig2_a == nscc_pkg::hex_upper(xor_a[3:0]))) ||
            ((dig1_a == nscc_pkg::hex_lower(xor_a[7:4])) &&
             (dig2_a == nscc_pkg::hex_lower(xor_a[3:0])));
    priority if (!star_a) begin
      res_o.status_code = nscc_pkg::STATUS_NO_STAR;
    end else if (!long_enough) begin
      res_o.status_code = nscc_pkg::STATUS_SHORT;
    end else if (!match) begin
      res_o.status_code = nscc_pkg::STATUS_MISMATCH;
    end else begin
      res_o.status_code = nscc_pkg::STATUS_OK;
    end
    res_o.checksum_ok  = (res_o.status_code == nscc_pkg::STATUS_OK);
    res_o.computed_sum = xor_a;
  end

  // next state, back to reset after the last character
  always_comb begin
    skip_d = skip_q;
    xor_d  = xor_q;
    star_d = star_q;
    cnt_d  = cnt_q;
    dig1_d = dig1_q;
    dig2_d = dig2_q;
    nl_d   = nl_q;
    if (fire_i) begin
      if (item_i.last_char) begin
        skip_d = 1'b1;
        xor_d  = nscc_pkg::SUM_INIT;
        star_d = 1'b0;
        cnt_d  = 3'd0;
        dig1_d = 8'h00;
        dig2_d = 8'h00;
        nl_d   = 1'b0;
      end else begin
        skip_d = skip_a;
        xor_d  = xor_a;
        star_d = star_a;
        cnt_d  = cnt_a;
        dig1_d = dig1_a;
        dig2_d = dig2_a;
        nl_d   = nl_a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b1;
      xor_q  <= nscc_pkg::SUM_INIT;
      star_q <= 1'b0;
      cnt_q  <= 3'd0;
      dig1_q <= 8'h00;
      dig2_q <= 8'h00;
      nl_q   <= 1'b0;
    end else begin
      skip_q <= skip_d;
      xor_q  <= xor_d;
      star_q <= star_d;
      cnt_q  <= cnt_d;
      dig1_q <= dig1_d;
      dig2_q <= dig2_d;
      nl_q   <= nl_d;
    end
  end

endmodule

[rtl/nscc_out_stage.sv]
// ----------------------------------------------------------------------------
// nscc_out_stage
// Result register: holds one line verdict until the output transfer.
// ----------------------------------------------------------------------------
module nscc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  nscc_pkg::out_item_t res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nscc_pkg::out_item_t out_data_o
);

  logic                valid_q, valid_d;
  nscc_pkg::out_item_t data_q;

  assign free_o = ~valid_q | ~out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/nmea_sentence_checksum_check.sv]
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_check
// Checks the checksum of an NMEA line fed one character per transfer and
// gives one verdict per line on its last character.
//
//   channel   direction  handshake                payload
//   in        input      in_valid_i / in_stall_o  in_data_i  (in_item_t)
//   out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
//
// one character per cycle sustained while no last character waits; the verdict
// of a line passes through the input register and then the result register
// before it is presented on the out channel
// reset returns the line state to its start, ready for the first character
// ordinary characters never wait on the output side; a last character waits
// in the input register while an earlier verdict is held by out_stall_i
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nscc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nscc_pkg::out_item_t out_data_o
);

  logic                s1_valid;
  nscc_pkg::in_item_t  s1_item;
  logic                s1_fire;
  logic                out_free;
  nscc_pkg::out_item_t res;

  assign s1_fire = s1_valid & (~s1_item.last_char | out_free);

  nscc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .fire_i     (s1_fire),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  nscc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_item),
    .res_o  (res)
  );

  nscc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire & s1_item.last_char),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_stall_only_on_held_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_item.last_char)
  ) else $error("input stalled without a held result");

  a_ok_matches_status: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.checksum_ok ==
                     (out_data_o.status_code == nscc_pkg::STATUS_OK))
  ) else $error("checksum_ok disagrees with status_code");

  a_result_from_last_char: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(s1_valid && s1_item.last_char)
  ) else $error("result without a last character");
`endif

endmodule
